FILE: rtl/imta_pkg.sv
// Shared constants, codes and the controller-to-datapath command struct of the triangle assembler.
package imta_pkg;

  localparam int BATCH_DEPTH = 32;
  localparam int ADDR_W = $clog2(BATCH_DEPTH);
  localparam int FILL_W = $clog2(BATCH_DEPTH + 1);
  // The only multiple of three for which one more list triangle no longer fits.
  localparam int LIST_FLUSH_FILL = (BATCH_DEPTH / 3) * 3;
  localparam int TAG_W = 32;
  localparam int CMD_W = 2;
  localparam int MODE_W = 2;

  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END = 2'd2;

  localparam logic [MODE_W-1:0] MODE_LIST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STRIP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FAN = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OTHER = 2'd3;

  typedef enum logic [1:0] {
    WR_TAG,
    WR_BEFORE,
    WR_HUB,
    WR_LAST
  } wr_sel_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    wr_sel_t           wr_sel;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [ADDR_W-1:0] rd_addr_c;
    logic              tag_shift;
    logic              hub_capture;
  } dp_cmd_t;

endpackage

FILE: rtl/imta_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module imta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/imta_dp.sv
// Datapath: three copies of the batch store, hub and carry tag registers.
module imta_dp (
  input  logic                              clk,
  input  imta_pkg::dp_cmd_t                 cmd,
  input  logic [imta_pkg::TAG_W-1:0]        in_vertex_tag,
  output logic [imta_pkg::TAG_W-1:0]        corner_a,
  output logic [imta_pkg::TAG_W-1:0]        corner_b,
  output logic [imta_pkg::TAG_W-1:0]        corner_c
);

  logic [imta_pkg::TAG_W-1:0] hub_r;
  logic [imta_pkg::TAG_W-1:0] last_r;
  logic [imta_pkg::TAG_W-1:0] before_r;
  logic [imta_pkg::TAG_W-1:0] wdata;

  // A strip carries over the two most recently stored tags, a fan the hub and the last.
  always_ff @(posedge clk) begin
    if (cmd.tag_shift) begin
      last_r   <= in_vertex_tag;
      before_r <= last_r;
    end
    if (cmd.hub_capture) begin
      hub_r <= in_vertex_tag;
    end
  end

  always_comb begin
    case (cmd.wr_sel)
      imta_pkg::WR_TAG:    wdata = in_vertex_tag;
      imta_pkg::WR_BEFORE: wdata = before_r;
      imta_pkg::WR_HUB:    wdata = hub_r;
      imta_pkg::WR_LAST:   wdata = last_r;
      default:             wdata = in_vertex_tag;
    endcase
  end

  // Every copy takes the same writes so that all three corners read at once.
  imta_ram #(.WIDTH(imta_pkg::TAG_W), .DEPTH(imta_pkg::BATCH_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (cmd.wr_addr),
    .wdata (wdata),
    .raddr (cmd.rd_addr_a),
    .rdata (corner_a)
  );

  imta_ram #(.WIDTH(imta_pkg::TAG_W), .DEPTH(imta_pkg::BATCH_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (cmd.wr_addr),
    .wdata (wdata),
    .raddr (cmd.rd_addr_b),
    .rdata (corner_b)
  );

  imta_ram #(.WIDTH(imta_pkg::TAG_W), .DEPTH(imta_pkg::BATCH_DEPTH)) u_ram_c (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (cmd.wr_addr),
    .wdata (wdata),
    .raddr (cmd.rd_addr_c),
    .rdata (corner_c)
  );

endmodule

FILE: rtl/imta_ctrl.sv
// Controller: command decode, fill count, flush sequencing and carry-over writes.
module imta_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [imta_pkg::CMD_W-1:0]         in_command,
  input  logic                               cfg_wr_en,
  input  logic [imta_pkg::MODE_W-1:0]        cfg_wr_data,
  output imta_pkg::dp_cmd_t                  cmd,
  output logic                               out_valid,
  output logic                               out_last_of_run
);

  localparam int FW = imta_pkg::FILL_W;
  localparam int EW = imta_pkg::FILL_W + 1;
  localparam int AW = imta_pkg::ADDR_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_CARRY0,
    ST_CARRY1
  } state_t;

  state_t                       state_r, state_nxt;
  logic [FW-1:0]                fill_r, fill_nxt;
  logic [FW-1:0]                idx_r, idx_nxt;
  logic                         carry_r, carry_nxt;
  logic                         hub_pending_r, hub_pending_nxt;
  logic [imta_pkg::MODE_W-1:0]  mode_r, mode_nxt;
  logic                         out_valid_nxt;
  logic                         out_last_nxt;

  always_comb begin
    logic          accept;
    logic          is_list;
    logic          odd;
    logic [FW-1:0] new_fill;
    logic [EW-1:0] n_ext;
    logic [EW-1:0] i1;
    logic [EW-1:0] i2;
    logic          tri_ok;
    logic          is_last;

    accept   = start && (state_r == ST_IDLE);
    is_list  = (mode_r == imta_pkg::MODE_LIST);
    odd      = idx_r[0];
    new_fill = fill_r + FW'(1);
    n_ext    = {1'b0, fill_r};
    i1       = {1'b0, idx_r} + EW'(1);
    i2       = {1'b0, idx_r} + EW'(2);
    tri_ok   = (mode_r != imta_pkg::MODE_OTHER) && (i2 < n_ext);
    is_last  = is_list ? ({1'b0, idx_r} + EW'(5) >= n_ext)
                       : ({1'b0, idx_r} + EW'(3) >= n_ext);

    state_nxt       = state_r;
    fill_nxt        = fill_r;
    idx_nxt         = idx_r;
    carry_nxt       = carry_r;
    hub_pending_nxt = hub_pending_r;
    mode_nxt        = cfg_wr_en ? cfg_wr_data : mode_r;
    out_valid_nxt   = 1'b0;
    out_last_nxt    = 1'b0;

    cmd.wr_en       = 1'b0;
    cmd.wr_addr     = fill_r[AW-1:0];
    cmd.wr_sel      = imta_pkg::WR_TAG;
    cmd.tag_shift   = 1'b0;
    cmd.hub_capture = 1'b0;

    // Corner addresses for the triangle at the current index.
    cmd.rd_addr_a = idx_r[AW-1:0];
    cmd.rd_addr_b = i1[AW-1:0];
    cmd.rd_addr_c = i2[AW-1:0];
    if (mode_r == imta_pkg::MODE_STRIP && odd) begin
      cmd.rd_addr_b = i2[AW-1:0];
      cmd.rd_addr_c = i1[AW-1:0];
    end else if (mode_r == imta_pkg::MODE_FAN) begin
      cmd.rd_addr_a = i1[AW-1:0];
      cmd.rd_addr_b = i2[AW-1:0];
      cmd.rd_addr_c = '0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_command)
            imta_pkg::CMD_BEGIN: begin
              fill_nxt        = '0;
              hub_pending_nxt = (mode_r == imta_pkg::MODE_FAN);
            end
            imta_pkg::CMD_ADD: begin
              // A full store can only happen after a mode change; the vertex is dropped.
              if (fill_r < FW'(imta_pkg::BATCH_DEPTH)) begin
                cmd.wr_en       = 1'b1;
                cmd.tag_shift   = 1'b1;
                cmd.hub_capture = hub_pending_r;
                hub_pending_nxt = 1'b0;
                fill_nxt        = new_fill;
                if (is_list ? (new_fill == FW'(imta_pkg::LIST_FLUSH_FILL))
                            : (new_fill == FW'(imta_pkg::BATCH_DEPTH))) begin
                  state_nxt = ST_FLUSH;
                  idx_nxt   = '0;
                  carry_nxt = (mode_r == imta_pkg::MODE_STRIP) ||
                              (mode_r == imta_pkg::MODE_FAN);
                end
              end
            end
            imta_pkg::CMD_END: begin
              state_nxt = ST_FLUSH;
              idx_nxt   = '0;
              carry_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FLUSH: begin
        if (tri_ok) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = is_last;
          idx_nxt       = idx_r + (is_list ? FW'(3) : FW'(1));
        end
        if (!tri_ok || is_last) begin
          if (carry_r) begin
            state_nxt = ST_CARRY0;
            fill_nxt  = FW'(2);
          end else begin
            state_nxt = ST_IDLE;
            fill_nxt  = '0;
          end
        end
      end
      ST_CARRY0: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = '0;
        cmd.wr_sel  = (mode_r == imta_pkg::MODE_STRIP) ? imta_pkg::WR_BEFORE
                                                       : imta_pkg::WR_HUB;
        state_nxt   = ST_CARRY1;
      end
      ST_CARRY1: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = AW'(1);
        cmd.wr_sel  = imta_pkg::WR_LAST;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      fill_r        <= '0;
      idx_r         <= '0;
      carry_r       <= 1'b0;
      hub_pending_r <= 1'b0;
      mode_r        <= imta_pkg::MODE_LIST;
      out_valid     <= 1'b0;
      out_last_of_run <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      fill_r        <= fill_nxt;
      idx_r         <= idx_nxt;
      carry_r       <= carry_nxt;
      hub_pending_r <= hub_pending_nxt;
      mode_r        <= mode_nxt;
      out_valid     <= out_valid_nxt;
      out_last_of_run <= out_last_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: rtl/immediate_mode_triangle_assembler_top.sv
// Top level of the immediate-mode triangle assembler: controller plus datapath.
//
// A command is transferred at a rising edge with start high and busy low.
// Begin clears the batch, add stores in_vertex_tag, end flushes the batch.
// cfg_wr_en with cfg_wr_data selects list, strip, fan or buffer-only mode;
// write it only while the block is idle.
// Begin, a plain add and an unknown command keep busy low,
// so such transfers can follow every cycle.
// A flush (end, or an add that fills the batch) raises busy. Triangles leave
// one per cycle, each for a single cycle marked by out_valid; the first
// follows the flush state's registered reads; out_last_of_run marks the last.
// A flush holds busy through the flush state, which emits the triangles, and,
// when a strip or fan rewrites its two carried vertices, through the carry
// states ST_CARRY0 and ST_CARRY1; the single write port of the batch store
// puts those two writes in separate states.
// The receiver cannot stall: every result must be taken when it is shown.
// Reset (rst_n low, synchronous) empties the batch and selects list mode;
// stored tags are not cleared.
module immediate_mode_triangle_assembler_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [imta_pkg::CMD_W-1:0]         in_command,
  input  logic [imta_pkg::TAG_W-1:0]         in_vertex_tag,
  input  logic                               cfg_wr_en,
  input  logic [imta_pkg::MODE_W-1:0]        cfg_wr_data,
  output logic                               out_valid,
  output logic [imta_pkg::TAG_W-1:0]         out_corner_a,
  output logic [imta_pkg::TAG_W-1:0]         out_corner_b,
  output logic [imta_pkg::TAG_W-1:0]         out_corner_c,
  output logic                               out_last_of_run
);

  imta_pkg::dp_cmd_t dp_cmd;

  imta_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (dp_cmd),
    .out_valid       (out_valid),
    .out_last_of_run (out_last_of_run)
  );

  imta_dp u_dp (
    .clk           (clk),
    .cmd           (dp_cmd),
    .in_vertex_tag (in_vertex_tag),
    .corner_a      (out_corner_a),
    .corner_b      (out_corner_b),
    .corner_c      (out_corner_c)
  );

endmodule
